@@ rtl/core/dd_odom_pkg.sv @@
// ----------------------------------------------------------------------------
// dd_odom_pkg
// Shared constants, codes and helper functions for the odometry unit.
// ----------------------------------------------------------------------------
package dd_odom_pkg;

  localparam int OP_W  = 2;
  localparam int IDX_W = 2;
  localparam int IT_W  = 5;   // angle table has 32 entries
  localparam int DIV_W = 78;  // widest dividend: 48-bit travel times 30-bit scale
  localparam int DSR_W = 40;  // widest divisor: 16-bit time times 24-bit axle

  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_SHIFT  = 2'd2;

  localparam logic [IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] CFG_AXLE_LENGTH    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INVERT_LEFT    = 2'd2;

  localparam logic [31:0] DIST_RESET = 32'd1000000;
  localparam logic [23:0] AXLE_RESET = 24'd32768;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] RAD_TO_BAM  = 32'd683565276;
  localparam logic [31:0] MS_PER_S    = 32'd1000;

  // Arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_bam(input logic [IT_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Round a Q30 magnitude product half away from zero, then apply the sign
  function automatic logic [31:0] round_q30(input logic [63:0] prod, input logic neg);
    logic [63:0] rs;
    logic [31:0] m;
    rs = prod + 64'h2000_0000;
    m  = rs[61:30];
    return neg ? (32'd0 - m) : m;
  endfunction

  // Saturate a quotient magnitude to a signed 32-bit value
  function automatic logic [31:0] sat_q(input logic [DIV_W-1:0] q, input logic neg);
    logic big;
    big = |q[DIV_W-1:31];
    if (neg) begin
      return big ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
    return big ? 32'h7FFF_FFFF : q[31:0];
  endfunction

endpackage

@@ rtl/core/differential_drive_odometry_unit.sv @@
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Fixed-point pose and velocity tracker for a two-wheeled robot.
// ----------------------------------------------------------------------------
// An encoder update beat runs three passes of one bit-serial restoring
// divider (41, 58 and 78 quotient bits) and then the CORDIC iterations
// before its result. Set, shift, unused-opcode and no-motion beats go
// straight from idle to the result state. The block takes one beat at a
// time: in_ready is high only while the sequencer is idle. Configuration
// writes are always taken and must only be issued while no beat is in
// flight. Positions and velocities are in 2^-16 units; heading is a
// 32-bit binary angle that wraps.
module differential_drive_odometry_unit #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dd_odom_pkg::IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [dd_odom_pkg::OP_W-1:0]         opcode,
  input  logic signed [15:0]                   left_count,
  input  logic signed [15:0]                   right_count,
  input  logic [15:0]                          elapsed_ms,
  input  logic signed [31:0]                   new_x,
  input  logic signed [31:0]                   new_y,
  input  logic [31:0]                          new_heading,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [31:0]                   pos_x,
  output logic signed [31:0]                   pos_y,
  output logic [31:0]                          heading,
  output logic signed [31:0]                   vel_forward,
  output logic signed [31:0]                   vel_turn,
  output logic                                 pose_changed
);
  import dd_odom_pkg::*;

  // CORDIC depth is capped by the angle table
  localparam int CORDIC_N = (TRIG_ITERATIONS > 32) ? 32 : TRIG_ITERATIONS;
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(CORDIC_N - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_D0, S_DIV, S_M4, S_M5, S_M6, S_D1,
    S_M7, S_M8, S_D2, S_CINIT, S_CORDIC, S_MX, S_MY, S_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {DV_FWD, DV_TURN, DV_ANG} div_op_t;

  state_t  state;
  div_op_t div_op;

  // Configuration
  logic [31:0] dist_per_count;
  logic [23:0] axle_len;
  logic        inv_left;
  logic [23:0] axle_eff;

  // Architectural state
  logic [31:0] x_pos, y_pos, hdg, vel_f, vel_t;
  logic        changed;

  // Per-beat working registers
  logic [15:0]  ms;
  logic [16:0]  sum_cnt_mag, diff_cnt_mag;
  logic         sum_neg, diff_pos;
  logic [47:0]  msum, mdiff;
  logic [63:0]  p;
  logic [53:0]  plo;
  logic [31:0]  ds_mag, turn, dx;
  logic         flip;
  logic signed [33:0] cx, cy, z;
  logic [IT_W-1:0] it;

  // Divider
  logic [DIV_W-1:0] dvd;
  logic [DSR_W-1:0] rem, dsr;
  logic [6:0]       cnt;

  // Combinational helpers
  logic [31:0]        mul_a, mul_b;
  logic [DSR_W:0]     rem_sh;
  logic               ge;
  logic [DSR_W-1:0]   rem_nx;
  logic [DIV_W-1:0]   q_nx;
  logic signed [16:0] l_in, r_in;
  logic signed [17:0] lsum_in, ldiff_in;
  logic [77:0]        wide;
  logic [48:0]        ds_tmp;
  logic signed [33:0] cfin, sfin, cabs, sabs, xs, ys, atan_z;
  logic [31:0]        ang_q, ang_a;
  logic               no_motion;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign axle_eff  = (axle_len == 24'd0) ? 24'd1 : axle_len;

  always_comb begin
    l_in      = inv_left ? -17'($signed(left_count)) : 17'($signed(left_count));
    r_in      = 17'($signed(right_count));
    lsum_in   = 18'(l_in) + 18'(r_in);
    ldiff_in  = 18'(r_in) - 18'(l_in);
    no_motion = (elapsed_ms == 16'd0) || (left_count == 16'sd0 && right_count == 16'sd0);

    wide   = (78'(p) << 24) + 78'(plo);
    ds_tmp = {1'b0, msum} + 49'h10000;

    rem_sh = {rem, dvd[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dsr};
    rem_nx = ge ? DSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DSR_W-1:0];
    q_nx   = {dvd[DIV_W-2:0], ge};

    xs     = cx >>> it;
    ys     = cy >>> it;
    atan_z = 34'(atan_bam(it));

    ang_q = hdg + 32'h4000_0000;
    ang_a = ang_q[31] ? (hdg + 32'h8000_0000) : hdg;

    cfin = flip ? -cx : cx;
    sfin = flip ? -cy : cy;
    cabs = cfin[33] ? -cfin : cfin;
    sabs = sfin[33] ? -sfin : sfin;

    // Shared multiplier operands
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      S_M0: begin mul_a = 32'(sum_cnt_mag);  mul_b = dist_per_count; end
      S_M1: begin mul_a = 32'(diff_cnt_mag); mul_b = dist_per_count; end
      S_M2: begin mul_a = 32'(msum[23:0]);   mul_b = MS_PER_S; end
      S_M3: begin mul_a = 32'(msum[47:24]);  mul_b = MS_PER_S; end
      S_M4: begin mul_a = 32'(mdiff[23:0]);  mul_b = MS_PER_S; end
      S_M5: begin mul_a = 32'(mdiff[47:24]); mul_b = MS_PER_S; end
      S_M6: begin mul_a = 32'(ms);           mul_b = 32'(axle_eff); end
      S_M7: begin mul_a = 32'(mdiff[23:0]);  mul_b = RAD_TO_BAM; end
      S_M8: begin mul_a = 32'(mdiff[47:24]); mul_b = RAD_TO_BAM; end
      S_MX: begin mul_a = ds_mag;            mul_b = cabs[31:0]; end
      S_MY: begin mul_a = ds_mag;            mul_b = sabs[31:0]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= 64'(mul_a) * 64'(mul_b);

    if (rst) begin
      state          <= S_IDLE;
      div_op         <= DV_FWD;
      dist_per_count <= DIST_RESET;
      axle_len       <= AXLE_RESET;
      inv_left       <= 1'b0;
      x_pos          <= 32'd0;
      y_pos          <= 32'd0;
      hdg            <= 32'd0;
      vel_f          <= 32'd0;
      vel_t          <= 32'd0;
      changed        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Register writes: an index beyond the list is dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIST_PER_COUNT: dist_per_count <= cfg_data;
          CFG_AXLE_LENGTH:    axle_len       <= cfg_data[23:0];
          CFG_INVERT_LEFT:    inv_left       <= cfg_data[0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ms           <= elapsed_ms;
            sum_neg      <= lsum_in[17];
            sum_cnt_mag  <= lsum_in[17] ? 17'(-lsum_in) : 17'(lsum_in);
            diff_pos     <= !ldiff_in[17] && (ldiff_in != 18'sd0);
            diff_cnt_mag <= ldiff_in[17] ? 17'(-ldiff_in) : 17'(ldiff_in);
            changed      <= 1'b0;
            state        <= S_DONE;
            case (opcode)
              OP_UPDATE: begin
                if (!no_motion) begin
                  state <= S_M0;
                end
              end
              OP_SET: begin
                x_pos   <= new_x;
                y_pos   <= new_y;
                hdg     <= new_heading;
                vel_f   <= 32'd0;
                vel_t   <= 32'd0;
                changed <= (new_x != x_pos) || (new_y != y_pos) || (new_heading != hdg);
              end
              OP_SHIFT: begin
                x_pos   <= x_pos + new_x;
                y_pos   <= y_pos + new_y;
                changed <= (new_x != 32'sd0) || (new_y != 32'sd0);
              end
              default: ;
            endcase
          end
        end
        // Wheel travel sum and difference, then scale by 1000 in two halves
        S_M0: state <= S_M1;
        S_M1: begin
          msum  <= p[47:0];
          state <= S_M2;
        end
        S_M2: begin
          mdiff <= p[47:0];
          state <= S_M3;
        end
        S_M3: begin
          plo   <= 54'(p);
          state <= S_D0;
        end
        S_D0: begin
          dvd    <= DIV_W'(wide >> 17) << (DIV_W - 41);
          dsr    <= DSR_W'(ms);
          rem    <= '0;
          cnt    <= 7'd41;
          div_op <= DV_FWD;
          ds_mag <= ds_tmp[48:17];
          state  <= S_DIV;
        end
        S_DIV: begin
          dvd <= q_nx;
          rem <= rem_nx;
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            case (div_op)
              DV_FWD: begin
                vel_f <= sat_q(q_nx, sum_neg);
                state <= S_M4;
              end
              DV_TURN: begin
                vel_t <= sat_q(q_nx, !diff_pos);
                state <= S_M7;
              end
              DV_ANG: begin
                turn  <= q_nx[47:16];
                state <= S_CINIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_M4: state <= S_M5;
        S_M5: begin
          plo   <= 54'(p);
          state <= S_M6;
        end
        S_M6: begin
          dvd   <= wide << (DIV_W - 58);
          state <= S_D1;
        end
        S_D1: begin
          // Divide by elapsed time times axle length
          dsr    <= p[DSR_W-1:0];
          rem    <= '0;
          cnt    <= 7'd58;
          div_op <= DV_TURN;
          state  <= S_DIV;
        end
        S_M7: state <= S_M8;
        S_M8: begin
          plo   <= p[53:0];
          state <= S_D2;
        end
        S_D2: begin
          dvd    <= wide;
          dsr    <= DSR_W'(axle_eff);
          rem    <= '0;
          cnt    <= 7'd78;
          div_op <= DV_ANG;
          state  <= S_DIV;
        end
        // Fold the heading into a quarter turn either side of zero
        S_CINIT: begin
          flip  <= ang_q[31];
          z     <= 34'($signed(ang_a));
          cx    <= CORDIC_GAIN;
          cy    <= 34'sd0;
          it    <= '0;
          state <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!z[33]) begin
            cx <= cx - ys;
            cy <= cy + xs;
            z  <= z - atan_z;
          end else begin
            cx <= cx + ys;
            cy <= cy - xs;
            z  <= z + atan_z;
          end
          if (it == IT_LAST) begin
            state <= S_MX;
          end else begin
            it <= it + 1'b1;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          dx    <= round_q30(p, sum_neg ^ cfin[33]);
          state <= S_FIN;
        end
        S_FIN: begin
          x_pos   <= x_pos + dx;
          y_pos   <= y_pos - round_q30(p, sum_neg ^ sfin[33]);
          hdg     <= diff_pos ? (hdg - turn) : (hdg + turn);
          changed <= (dx != 32'd0) || (round_q30(p, sum_neg ^ sfin[33]) != 32'd0) ||
                     (turn != 32'd0);
          state   <= S_DONE;
        end
        // Hold the result until the output register is free
        S_DONE: begin
          if (!out_valid || out_ready) begin
            pos_x        <= x_pos;
            pos_y        <= y_pos;
            heading      <= hdg;
            vel_forward  <= vel_f;
            vel_turn     <= vel_t;
            pose_changed <= changed;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
